// ----- hw/rtl/rcf_pkg.sv -----
// Shared types and constants for the first-order RC filter.
// Holds the request structs, history word layout and register map.
// No dependencies.
package rcf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;
	localparam int OUT_CH_W    = 3;

	localparam int DIFF_W = SAMPLE_BITS + 2;
	localparam int PROD_W = DIFF_W + COEF_BITS + 1;
	localparam int SUM_W  = DIFF_W + 2;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_CNT_W  = 4;

	localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_COEFFICIENT   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	localparam logic MODE_LOW_PASS  = 1'b0;
	localparam logic MODE_HIGH_PASS = 1'b1;

	localparam logic [COEF_BITS-1:0] COEF_RESET  = 16'd32768;
	localparam logic [CFG_CNT_W-1:0] COUNT_RESET = 4'd2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          buffer_start;
	} rcf_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [OUT_CH_W-1:0]           channel_of_sample;
	} rcf_out_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] y;
		logic [SAMPLE_BITS-1:0] x;
	} rcf_hist_t;

endpackage

// ----- hw/rtl/first_order_rc_filter.sv -----
// First-order RC low-pass / high-pass filter over an interleaved multi-channel stream.
// Per-channel history lives in one synchronous memory; depends on rcf_pkg.
// Channel    Direction  Handshake             Payload
// cfg        in         cfg_we                cfg_addr, cfg_wdata
// in         in         in_valid / in_ready   in_data (rcf_in_t)
// out        out        out_valid / out_ready out_data (rcf_out_t)
// One request is taken per cycle unless a hazard or a stalled output holds it; a stalled output
// holds every stage that cannot move forward. Each result passes stage one, the multiplier stage,
// stage three and the output register. A request whose channel equals that of the request directly
// ahead of it, and that starts no buffer, waits in the first stage while the multiplier stage holds
// the history it needs. Reset clears control state and valid bits; the memory needs no clearing pass.
module first_order_rc_filter import rcf_pkg::*; #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rcf_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rcf_out_t              out_data
);

	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W = ($clog2(MAX_CHANNELS + 1) > CFG_CNT_W) ?
		$clog2(MAX_CHANNELS + 1) : CFG_CNT_W;
	localparam int CHX_W = (CH_W > OUT_CH_W) ? CH_W : OUT_CH_W;
	localparam int SB    = SAMPLE_BITS;

	logic                 mode_q;
	logic [COEF_BITS-1:0] coef_q;
	logic [CFG_CNT_W-1:0] count_q;

	logic [CH_W-1:0]         idx_q;
	logic [MAX_CHANNELS-1:0] vld_q;
	rcf_hist_t               hist_mem [MAX_CHANNELS];

	logic                 v_s1, start_s1, hit_s1;
	logic [CH_W-1:0]      ch_s1;
	logic [SB-1:0]        x_s1;
	rcf_hist_t            rd_s1;

	logic                     v_s2, start_s2;
	logic [CH_W-1:0]          ch_s2;
	logic [SB-1:0]            x_s2, yp_s2;
	logic signed [DIFF_W-1:0] d_s2;

	logic                     v_s3, start_s3;
	logic [CH_W-1:0]          ch_s3;
	logic [SB-1:0]            x_s3, yp_s3;
	logic signed [PROD_W-1:0] prod_s3;

	logic            wb_v_q;
	logic [CH_W-1:0] wb_ch_q;
	rcf_hist_t       wb_q;

	logic     out_valid_q;
	rcf_out_t out_q;

	logic out_free, s3_free, s2_free, adv3, adv2, haz, s1_go, s1_free, in_acc;
	logic start_in;
	logic [CNT_W-1:0] count_ext, cnt_eff, ch_next_ext;
	logic [CH_W-1:0]  ch_cur, idx_d, rd_addr;
	logic             fwd3, fwdw, wr_valid_set;
	rcf_hist_t        prev, hist_wr;
	logic signed [DIFF_W-1:0]      xs_e, yp_e, xp_e, d_s1;
	logic signed [COEF_BITS:0]     coef_s;
	logic signed [PROD_W-1:0]      prod;
	logic signed [DIFF_W:0]        shifted;
	logic signed [SUM_W-1:0]       sum;
	logic [SUM_W-SB:0]             sum_hi;
	logic [SB-1:0]                 y_s3;
	logic [CHX_W-1:0]              ch_out_ext;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LOW_PASS;
			coef_q  <= COEF_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FILTER_MODE:   mode_q  <= cfg_wdata[0];
				REG_COEFFICIENT:   coef_q  <= cfg_wdata[COEF_BITS-1:0];
				REG_CHANNEL_COUNT: count_q <= cfg_wdata[CFG_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign s3_free  = !v_s3 || out_free;
	assign adv3     = v_s3 && out_free;
	assign s2_free  = !v_s2 || s3_free;
	assign adv2     = v_s2 && s3_free;
	assign haz      = v_s1 && v_s2 && !start_s1 && (ch_s2 == ch_s1);
	assign s1_go    = v_s1 && s2_free && !haz;
	assign s1_free  = !v_s1 || s1_go;
	assign in_ready = s1_free;
	assign in_acc   = in_valid && in_ready;
	assign start_in = in_data.buffer_start;

	// Channel selection and wrap.
	always_comb begin
		count_ext = CNT_W'(count_q);
		if (count_ext == '0)
			cnt_eff = CNT_W'(1);
		else if (count_ext > CNT_W'(MAX_CHANNELS))
			cnt_eff = CNT_W'(MAX_CHANNELS);
		else
			cnt_eff = count_ext;
		if (start_in || (CNT_W'(idx_q) >= CNT_W'(MAX_CHANNELS)))
			ch_cur = '0;
		else
			ch_cur = idx_q;
		ch_next_ext = CNT_W'(ch_cur) + CNT_W'(1);
		idx_d = (ch_next_ext >= cnt_eff) ? '0 : ch_next_ext[CH_W-1:0];
	end

	assign rd_addr = in_acc ? ch_cur : ch_s1;

	// History memory: one write port from the last stage, one registered read port.
	always_ff @(posedge clk) begin
		if (adv3)
			hist_mem[ch_s3] <= hist_wr;
		rd_s1 <= hist_mem[rd_addr];
	end

	// A write from an item older than a pending buffer start leaves its entry invalid.
	assign wr_valid_set = adv3 && !(v_s2 && start_s2) && !(v_s1 && start_s1) &&
		!(in_acc && start_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			vld_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			wb_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc)
				idx_q <= idx_d;
			if (in_acc && start_in)
				vld_q <= '0;
			else if (wr_valid_set)
				vld_q[ch_s3] <= 1'b1;
			if (s1_free)
				v_s1 <= in_valid;
			if (s2_free)
				v_s2 <= s1_go;
			if (s3_free)
				v_s3 <= adv2;
			if (adv3)
				wb_v_q <= 1'b1;
			if (out_free)
				out_valid_q <= v_s3;
		end
	end

	// Stage one: history select with forwarding, then the difference term.
	assign fwd3 = v_s3 && !start_s1 && !(v_s2 && start_s2) && (ch_s3 == ch_s1);
	assign fwdw = wb_v_q && !start_s1 && !(v_s2 && start_s2) && !(v_s3 && start_s3) &&
		(wb_ch_q == ch_s1);

	always_comb begin
		if (start_s1)
			prev = '0;
		else if (fwd3)
			prev = hist_wr;
		else if (fwdw)
			prev = wb_q;
		else if (hit_s1)
			prev = rd_s1;
		else
			prev = '0;
		xs_e = DIFF_W'($signed(x_s1));
		yp_e = DIFF_W'($signed(prev.y));
		xp_e = DIFF_W'($signed(prev.x));
		if (mode_q == MODE_HIGH_PASS)
			d_s1 = yp_e + xs_e - xp_e;
		else
			d_s1 = xs_e - yp_e;
	end

	// Stage two: coefficient multiply.
	assign coef_s = $signed({1'b0, coef_q});
	assign prod   = coef_s * d_s2;

	// Stage three: floor shift, low-pass accumulate and saturation.
	always_comb begin
		shifted = $signed(prod_s3[PROD_W-1:COEF_BITS]);
		if (mode_q == MODE_HIGH_PASS)
			sum = SUM_W'(shifted);
		else
			sum = SUM_W'(shifted) + SUM_W'($signed(yp_s3));
		sum_hi = sum[SUM_W-1:SB-1];
		if ((sum_hi == '0) || (sum_hi == '1))
			y_s3 = sum[SB-1:0];
		else
			y_s3 = {sum[SUM_W-1], {(SB-1){~sum[SUM_W-1]}}};
		hist_wr.y  = y_s3;
		hist_wr.x  = x_s3;
		ch_out_ext = CHX_W'(ch_s3);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_s1    <= ch_cur;
			x_s1     <= in_data.sample_in;
			start_s1 <= start_in;
		end
		hit_s1 <= vld_q[rd_addr] && !(in_acc && start_in);
		if (s1_go) begin
			ch_s2    <= ch_s1;
			x_s2     <= x_s1;
			yp_s2    <= prev.y;
			d_s2     <= d_s1;
			start_s2 <= start_s1;
		end
		if (adv2) begin
			ch_s3    <= ch_s2;
			x_s3     <= x_s2;
			yp_s3    <= yp_s2;
			prod_s3  <= prod;
			start_s3 <= start_s2;
		end
		if (adv3) begin
			wb_ch_q                 <= ch_s3;
			wb_q                    <= hist_wr;
			out_q.sample_out        <= $signed(y_s3);
			out_q.channel_of_sample <= ch_out_ext[OUT_CH_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_start_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && start_in) |=> (vld_q == '0))
		else $error("history valid bits not cleared by buffer start");

	a_channel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (CNT_W'(ch_s1) < CNT_W'(MAX_CHANNELS)))
		else $error("stage one channel beyond memory depth");

	a_hazard_holds: assert property (@(posedge clk) disable iff (!arst_n)
		haz |=> (v_s1 && (ch_s1 == $past(ch_s1))))
		else $error("request left stage one during a same-channel hazard");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("request accepted while every stage is blocked");

endmodule
